[rtl/core/multi_image_median_prox_defines.svh]
// ---------------------------------------------------------------------------
// multi_image_median_prox assertion macros
// shared property wrappers for the checker of the median prox block
// ---------------------------------------------------------------------------
`ifndef MULTI_IMAGE_MEDIAN_PROX_DEFINES_SVH
`define MULTI_IMAGE_MEDIAN_PROX_DEFINES_SVH

// same-cycle implication, off while reset is high
`define MIMP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define MIMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds through reset
`define MIMP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/mimp_pkg.sv]
// ---------------------------------------------------------------------------
// mimp_pkg
// constants and control types shared by the median prox lanes and merge
// ---------------------------------------------------------------------------
package mimp_pkg;

   localparam int DEF_NUM_IMAGES = 8;
   localparam int DEF_VALUE_BITS = 16;
   localparam int MAX_IMAGES     = 8;

   localparam int STEP_BITS            = 16;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd4096;

   // Q.12 product back to Q.6 with round half up
   localparam int FRAC_SHIFT = 6;
   localparam int ROUND_BIAS = 32;

   typedef struct packed {
      logic ld_weight;
      logic ld_prod;
      logic ld_shift;
   } lane_ctl_type;

   typedef struct packed {
      logic ld_rel;
      logic ld_rank;
      logic ld_out;
   } merge_ctl_type;

endpackage

[rtl/core/multi_image_median_prox.sv]
// ---------------------------------------------------------------------------
// multi_image_median_prox
// per-pixel median proximal step over several observed images
//
//   channel   ports                       direction
//   req       req_valid/req_stall, obs    in   one pixel per transaction
//   rsp       rsp_valid/rsp_stall, median out  one result per transaction
//   csr       csr_wr_en/csr_wr_data       in   step_scale register
//
// one pixel per cycle sustained while rsp_stall is low; the stages are the lane
// pipeline (weight, multiply, shift) and the merge (compare, rank, average)
// reset clears the stage valids and loads step_scale with 1.0
// a stalled result holds the last stage; empty stages ahead still fill
// ---------------------------------------------------------------------------
module multi_image_median_prox #(
   parameter int NUM_IMAGES = mimp_pkg::DEF_NUM_IMAGES,
   parameter int VALUE_BITS = mimp_pkg::DEF_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [VALUE_BITS-1:0]              req_obs_0,
   input  logic [VALUE_BITS-1:0]              req_obs_1,
   input  logic [VALUE_BITS-1:0]              req_obs_2,
   input  logic [VALUE_BITS-1:0]              req_obs_3,
   input  logic [VALUE_BITS-1:0]              req_obs_4,
   input  logic [VALUE_BITS-1:0]              req_obs_5,
   input  logic [VALUE_BITS-1:0]              req_obs_6,
   input  logic [VALUE_BITS-1:0]              req_obs_7,
   input  logic [VALUE_BITS-1:0]              req_estimate,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [VALUE_BITS-1:0]              rsp_median_value,
   input  logic                               csr_wr_en,
   input  logic [mimp_pkg::STEP_BITS-1:0]     csr_wr_data
);
   import mimp_pkg::*;

   localparam int PIPE_STAGES = 6;

   logic [STEP_BITS-1:0]                     step_scale_ff;
   logic [PIPE_STAGES-1:0]                   valid_ff, valid_in;
   logic [PIPE_STAGES:0]                     ready;
   logic [MAX_IMAGES-1:0][VALUE_BITS-1:0]    obs_all;
   logic [NUM_IMAGES-1:0][VALUE_BITS-1:0]    obs_vec;
   logic [2*NUM_IMAGES-1:0][VALUE_BITS-1:0]  stack;
   lane_ctl_type                             lane_ctl;
   merge_ctl_type                            merge_ctl;

   assign obs_all = {req_obs_7, req_obs_6, req_obs_5, req_obs_4,
                     req_obs_3, req_obs_2, req_obs_1, req_obs_0};
   assign obs_vec = obs_all[NUM_IMAGES-1:0];

   // a stage loads when it is empty or the stage after it moves
   always_comb begin
      ready[PIPE_STAGES] = !rsp_stall;
      for (int s = PIPE_STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
      valid_in = {valid_ff[PIPE_STAGES-2:0], req_valid};
   end

   assign req_stall = !ready[0];

   assign lane_ctl.ld_weight = ready[0];
   assign lane_ctl.ld_prod   = ready[1];
   assign lane_ctl.ld_shift  = ready[2];
   assign merge_ctl.ld_rel   = ready[3];
   assign merge_ctl.ld_rank  = ready[4];
   assign merge_ctl.ld_out   = ready[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         step_scale_ff <= STEP_RESET;
      end else begin
         for (int s = 0; s < PIPE_STAGES; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
         if (csr_wr_en) begin
            step_scale_ff <= csr_wr_data;
         end
      end
   end

   for (genvar k = 0; k < NUM_IMAGES; k++) begin : g_lane
      mimp_lane #(
         .NUM_IMAGES (NUM_IMAGES),
         .VALUE_BITS (VALUE_BITS),
         .LANE_IDX   (k)
      ) u_lane (
         .clock       (clock),
         .ctl         (lane_ctl),
         .step_scale  (step_scale_ff),
         .obs_vec     (obs_vec),
         .estimate    (req_estimate),
         .obs_out     (stack[k]),
         .shifted_out (stack[NUM_IMAGES + k])
      );
   end

   mimp_merge #(
      .NUM_IMAGES (NUM_IMAGES),
      .VALUE_BITS (VALUE_BITS)
   ) u_merge (
      .clock        (clock),
      .ctl          (merge_ctl),
      .stack        (stack),
      .median_value (rsp_median_value)
   );

   assign rsp_valid = valid_ff[PIPE_STAGES-1];

endmodule

[rtl/core/mimp_lane.sv]
// ---------------------------------------------------------------------------
// mimp_lane
// one observation: rank weight, scaled step, shifted and saturated estimate
// ---------------------------------------------------------------------------
module mimp_lane #(
   parameter int NUM_IMAGES = mimp_pkg::DEF_NUM_IMAGES,
   parameter int VALUE_BITS = mimp_pkg::DEF_VALUE_BITS,
   parameter int LANE_IDX   = 0
) (
   input  logic                                   clock,
   input  mimp_pkg::lane_ctl_type                 ctl,
   input  logic [mimp_pkg::STEP_BITS-1:0]         step_scale,
   input  logic [NUM_IMAGES-1:0][VALUE_BITS-1:0]  obs_vec,
   input  logic [VALUE_BITS-1:0]                  estimate,
   output logic [VALUE_BITS-1:0]                  obs_out,
   output logic [VALUE_BITS-1:0]                  shifted_out
);
   import mimp_pkg::*;

   localparam int WGT_BITS  = $clog2(NUM_IMAGES) + 1;
   localparam int PROD_BITS = STEP_BITS + 1 + WGT_BITS;
   localparam int ACC_BITS  = ((VALUE_BITS > PROD_BITS) ? VALUE_BITS : PROD_BITS) + 2;
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      ACC_BITS'((longint'(1) <<< (VALUE_BITS - 1)) - longint'(1));
   localparam logic signed [ACC_BITS-1:0] SAT_LO =
      ACC_BITS'(-(longint'(1) <<< (VALUE_BITS - 1)));

   logic signed [WGT_BITS-1:0]   weight_in, weight_ff;
   logic [VALUE_BITS-1:0]        obs0_ff, est0_ff;
   logic signed [PROD_BITS-1:0]  prod_in, prod_ff;
   logic [VALUE_BITS-1:0]        obs1_ff, est1_ff;
   logic signed [ACC_BITS-1:0]   rounded, acc;
   logic [VALUE_BITS-1:0]        shifted_in, shifted_ff, obs2_ff;

   // rank weight: count below minus count above, ties count as neither
   always_comb begin
      weight_in = '0;
      for (int j = 0; j < NUM_IMAGES; j++) begin
         if ($signed(obs_vec[LANE_IDX]) > $signed(obs_vec[j])) begin
            weight_in = weight_in + WGT_BITS'(1);
         end else if ($signed(obs_vec[LANE_IDX]) < $signed(obs_vec[j])) begin
            weight_in = weight_in - WGT_BITS'(1);
         end
      end
   end

   assign prod_in = PROD_BITS'(signed'({1'b0, step_scale})) * PROD_BITS'(weight_ff);

   always_comb begin
      rounded = (ACC_BITS'(prod_ff) + ACC_BITS'(ROUND_BIAS)) >>> FRAC_SHIFT;
      acc     = rounded + ACC_BITS'($signed(est1_ff));
      if (acc > SAT_HI) begin
         shifted_in = SAT_HI[VALUE_BITS-1:0];
      end else if (acc < SAT_LO) begin
         shifted_in = SAT_LO[VALUE_BITS-1:0];
      end else begin
         shifted_in = acc[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_weight) begin
         weight_ff <= weight_in;
         obs0_ff   <= obs_vec[LANE_IDX];
         est0_ff   <= estimate;
      end
      if (ctl.ld_prod) begin
         prod_ff <= prod_in;
         obs1_ff <= obs0_ff;
         est1_ff <= est0_ff;
      end
      if (ctl.ld_shift) begin
         shifted_ff <= shifted_in;
         obs2_ff    <= obs1_ff;
      end
   end

   assign obs_out     = obs2_ff;
   assign shifted_out = shifted_ff;

endmodule

[rtl/core/mimp_merge.sv]
// ---------------------------------------------------------------------------
// mimp_merge
// ranks the stacked lane values and averages the two middle ones
// ---------------------------------------------------------------------------
module mimp_merge #(
   parameter int NUM_IMAGES = mimp_pkg::DEF_NUM_IMAGES,
   parameter int VALUE_BITS = mimp_pkg::DEF_VALUE_BITS
) (
   input  logic                                      clock,
   input  mimp_pkg::merge_ctl_type                   ctl,
   input  logic [2*NUM_IMAGES-1:0][VALUE_BITS-1:0]   stack,
   output logic [VALUE_BITS-1:0]                     median_value
);
   import mimp_pkg::*;

   localparam int STACK_LEN = 2 * NUM_IMAGES;
   localparam int RANK_BITS = $clog2(STACK_LEN);
   localparam logic [RANK_BITS-1:0] RANK_LO = RANK_BITS'(NUM_IMAGES - 1);
   localparam logic [RANK_BITS-1:0] RANK_HI = RANK_BITS'(NUM_IMAGES);

   logic [STACK_LEN-1:0][STACK_LEN-1:0]  rel_in, rel_ff;
   logic [STACK_LEN-1:0][VALUE_BITS-1:0] vals3_ff, vals4_ff;
   logic [STACK_LEN-1:0][RANK_BITS-1:0]  rank_in, rank_ff;
   logic [VALUE_BITS-1:0]                lo_val, hi_val, median_ff;
   logic signed [VALUE_BITS:0]           mid_sum;

   // rel[i][j]: element j sorts ahead of element i, equal values by position
   always_comb begin
      for (int i = 0; i < STACK_LEN; i++) begin
         for (int j = 0; j < STACK_LEN; j++) begin
            rel_in[i][j] = ($signed(stack[j]) < $signed(stack[i])) ||
                           ((j < i) && (stack[j] == stack[i]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < STACK_LEN; i++) begin
         rank_in[i] = RANK_BITS'($countones(rel_ff[i]));
      end
   end

   // ranks are unique, so an or-mux picks each middle entry
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < STACK_LEN; i++) begin
         if (rank_ff[i] == RANK_LO) begin
            lo_val = lo_val | vals4_ff[i];
         end
         if (rank_ff[i] == RANK_HI) begin
            hi_val = hi_val | vals4_ff[i];
         end
      end
      mid_sum = (VALUE_BITS+1)'($signed(lo_val)) + (VALUE_BITS+1)'($signed(hi_val));
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_rel) begin
         rel_ff   <= rel_in;
         vals3_ff <= stack;
      end
      if (ctl.ld_rank) begin
         rank_ff  <= rank_in;
         vals4_ff <= vals3_ff;
      end
      if (ctl.ld_out) begin
         median_ff <= mid_sum[VALUE_BITS:1];
      end
   end

   assign median_value = median_ff;

endmodule

[rtl/core/mimp_checker.sv]
// ---------------------------------------------------------------------------
// mimp_checker
// port-level checks of the median prox block, bound to the top level
// ---------------------------------------------------------------------------
`include "multi_image_median_prox_defines.svh"

module mimp_checker #(
   parameter int VALUE_BITS = mimp_pkg::DEF_VALUE_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [VALUE_BITS-1:0]  rsp_median_value
);

   logic rsp_blocked;

   assign rsp_blocked = rsp_valid && rsp_stall;

   // input only backs up when every stage holds a stalled result
   `MIMP_ASSERT_NOW(a_req_stall_full, clock, reset, req_stall, rsp_blocked, "early req_stall")

   `MIMP_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid, "valid after reset")

   `MIMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_blocked, rsp_valid, "stalled result dropped")

   `MIMP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_blocked, $stable(rsp_median_value), "data moved")

endmodule

bind multi_image_median_prox mimp_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (.*);
